[hw/rtl/lgca_pkg.sv]
// Shared types and constants for the light grid cell append unit.
// Used by every module under hw/rtl except lgca_ram; depends on nothing.
`default_nettype none

package lgca_pkg;

   // Storage sizing
   localparam int MAX_CELLS           = 32768;
   localparam int SLOTS_PER_CELL      = 32;
   localparam int SURFACE_INDEX_LIMIT = 256;

   localparam int CELL_AW  = $clog2(MAX_CELLS);
   localparam int SLOT_AW  = $clog2(SLOTS_PER_CELL);
   localparam int COUNT_W  = $clog2(SLOTS_PER_CELL + 1);
   localparam int SURF_W   = $clog2(SURFACE_INDEX_LIMIT);
   localparam int LIST_AW  = CELL_AW + SLOT_AW;
   localparam int COORD_W  = 8;
   localparam int SIZE_W   = 6;
   // x + y*sx + z*sx*sy with every term below 64 stays below 2^19
   localparam int IDX_W    = 19;
   localparam int CSR_AW   = 2;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_GRID_X = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GRID_Y = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_GRID_Z = 2'd2;

   typedef enum logic [1:0] {
      STATUS_APPENDED = 2'd0,
      STATUS_OUTSIDE  = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cell_x;
      logic signed [COORD_W-1:0] cell_y;
      logic signed [COORD_W-1:0] cell_z;
      logic [SURF_W-1:0]         light_id;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [CELL_AW-1:0] cell_index;
      logic [SLOT_AW-1:0] slot;
      logic [COUNT_W-1:0] count_after;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
   } grid_cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_IDX,
      ST_READ,
      ST_UPDATE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic mul;
      logic idx;
      logic update;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/lgca_ram.sv]
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module lgca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     we,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/lgca_ctrl.sv]
// Sequencer for the append unit: clearing pass, then one item at a time.
// Depends on lgca_pkg.
`default_nettype none

module lgca_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire lgca_pkg::dp_status_type dp_status,
   output lgca_pkg::dp_cmd_type        dp_cmd,
   output logic                        busy
);

   lgca_pkg::state_type state_ff;
   lgca_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgca_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      busy     = 1'b1;
      case (state_ff)
         lgca_pkg::ST_CLEAR: begin
            dp_cmd.clear = 1'b1;
            if (dp_status.clear_done) begin
               state_in = lgca_pkg::ST_IDLE;
            end
         end
         lgca_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = lgca_pkg::ST_MUL;
            end
         end
         lgca_pkg::ST_MUL: begin
            dp_cmd.mul = 1'b1;
            state_in   = lgca_pkg::ST_IDX;
         end
         lgca_pkg::ST_IDX: begin
            dp_cmd.idx = 1'b1;
            state_in   = lgca_pkg::ST_READ;
         end
         lgca_pkg::ST_READ: begin
            // count RAM read is in flight
            state_in = lgca_pkg::ST_UPDATE;
         end
         lgca_pkg::ST_UPDATE: begin
            dp_cmd.update = 1'b1;
            state_in      = lgca_pkg::ST_IDLE;
         end
         default: begin
            state_in = lgca_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/lgca_dp.sv]
// Datapath: range check, linear index, count RAM read-modify-write, list RAM.
// Depends on lgca_pkg and lgca_ram.
`default_nettype none

module lgca_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lgca_pkg::grid_cfg_type grid_cfg,
   input  wire lgca_pkg::req_type      req_item,
   input  wire lgca_pkg::dp_cmd_type   dp_cmd,
   output lgca_pkg::dp_status_type     dp_status,
   output logic                        rsp_strobe,
   output lgca_pkg::rsp_type           rsp_item
);

   localparam int PROD_W = 2 * lgca_pkg::SIZE_W;
   localparam int ZT_W   = lgca_pkg::SIZE_W + PROD_W;

   lgca_pkg::req_type          item_ff;
   logic                       bad_ff;
   logic [PROD_W-1:0]          ysx_ff;
   logic [PROD_W-1:0]          sxsy_ff;
   logic [lgca_pkg::IDX_W-1:0] idx_ff;
   logic [lgca_pkg::CELL_AW-1:0] clr_addr_ff;
   logic                       strobe_ff;
   lgca_pkg::rsp_type          rsp_ff;

   logic                       x_ok;
   logic                       y_ok;
   logic                       z_ok;
   logic [ZT_W-1:0]            zterm;
   logic [lgca_pkg::IDX_W-1:0] idx_in;
   logic                       outside;
   logic                       full;
   logic                       append;
   logic [lgca_pkg::COUNT_W-1:0] count_rd;
   logic [lgca_pkg::COUNT_W-1:0] count_inc;
   logic [lgca_pkg::CELL_AW-1:0] cnt_addr;
   logic                       cnt_we;
   logic [lgca_pkg::COUNT_W-1:0] cnt_wdata;
   logic [lgca_pkg::COUNT_W-1:0] cnt_rdata_w;
   logic [lgca_pkg::LIST_AW-1:0] list_addr;
   logic [lgca_pkg::SURF_W-1:0]  list_rdata;

   // Non-negative and below the grid size
   assign x_ok = !item_ff.cell_x[lgca_pkg::COORD_W-1]
              && (item_ff.cell_x[lgca_pkg::COORD_W-2:0] < {1'b0, grid_cfg.size_x});
   assign y_ok = !item_ff.cell_y[lgca_pkg::COORD_W-1]
              && (item_ff.cell_y[lgca_pkg::COORD_W-2:0] < {1'b0, grid_cfg.size_y});
   assign z_ok = !item_ff.cell_z[lgca_pkg::COORD_W-1]
              && (item_ff.cell_z[lgca_pkg::COORD_W-2:0] < {1'b0, grid_cfg.size_z});

   // In range, each coordinate fits in SIZE_W bits
   assign zterm  = item_ff.cell_z[lgca_pkg::SIZE_W-1:0] * sxsy_ff;
   assign idx_in = lgca_pkg::IDX_W'(item_ff.cell_x[lgca_pkg::SIZE_W-1:0])
                 + lgca_pkg::IDX_W'(ysx_ff)
                 + lgca_pkg::IDX_W'(zterm);

   assign outside   = bad_ff || (idx_ff[lgca_pkg::IDX_W-1:lgca_pkg::CELL_AW] != '0);
   assign count_rd  = cnt_rdata_w;
   assign full      = count_rd >= lgca_pkg::COUNT_W'(lgca_pkg::SLOTS_PER_CELL);
   assign append    = dp_cmd.update && !outside && !full;
   assign count_inc = count_rd + lgca_pkg::COUNT_W'(1);

   assign cnt_addr  = dp_cmd.clear ? clr_addr_ff : idx_ff[lgca_pkg::CELL_AW-1:0];
   assign cnt_we    = dp_cmd.clear || append;
   assign cnt_wdata = dp_cmd.clear ? '0 : count_inc;
   assign list_addr = {idx_ff[lgca_pkg::CELL_AW-1:0], count_rd[lgca_pkg::SLOT_AW-1:0]};

   assign dp_status.clear_done = clr_addr_ff == lgca_pkg::CELL_AW'(lgca_pkg::MAX_CELLS - 1);

   lgca_ram #(
      .WIDTH (lgca_pkg::COUNT_W),
      .DEPTH (lgca_pkg::MAX_CELLS)
   ) u_count_ram (
      .clock (clock),
      .addr  (cnt_addr),
      .we    (cnt_we),
      .wdata (cnt_wdata),
      .rdata (cnt_rdata_w)
   );

   // Light lists are write-only here
   lgca_ram #(
      .WIDTH (lgca_pkg::SURF_W),
      .DEPTH (lgca_pkg::MAX_CELLS * lgca_pkg::SLOTS_PER_CELL)
   ) u_list_ram (
      .clock (clock),
      .addr  (list_addr),
      .we    (append),
      .wdata (item_ff.light_id),
      .rdata (list_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         if (dp_cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + lgca_pkg::CELL_AW'(1);
         end
         strobe_ff <= dp_cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         item_ff <= req_item;
      end
      if (dp_cmd.mul) begin
         bad_ff  <= !(x_ok && y_ok && z_ok);
         ysx_ff  <= item_ff.cell_y[lgca_pkg::SIZE_W-1:0] * grid_cfg.size_x;
         sxsy_ff <= grid_cfg.size_x * grid_cfg.size_y;
      end
      if (dp_cmd.idx) begin
         idx_ff <= idx_in;
      end
      if (dp_cmd.update) begin
         if (outside) begin
            rsp_ff.status      <= lgca_pkg::STATUS_OUTSIDE;
            rsp_ff.cell_index  <= '0;
            rsp_ff.slot        <= '0;
            rsp_ff.count_after <= '0;
         end else if (full) begin
            rsp_ff.status      <= lgca_pkg::STATUS_FULL;
            rsp_ff.cell_index  <= idx_ff[lgca_pkg::CELL_AW-1:0];
            rsp_ff.slot        <= '0;
            rsp_ff.count_after <= count_rd;
         end else begin
            rsp_ff.status      <= lgca_pkg::STATUS_APPENDED;
            rsp_ff.cell_index  <= idx_ff[lgca_pkg::CELL_AW-1:0];
            rsp_ff.slot        <= count_rd[lgca_pkg::SLOT_AW-1:0];
            rsp_ff.count_after <= count_inc;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/light_grid_cell_append_unit.sv]
// Top level of the light grid cell append unit: grid size registers,
// sequencer and datapath. Depends on lgca_pkg, lgca_ctrl, lgca_dp.
//
//   channel   ports                          transfer
//   request   start, busy, req_item          start && !busy
//   response  rsp_strobe, rsp_item           one cycle per strobe, no stall
//   csr       csr_we, csr_index, csr_wdata   csr_we, no wait
//
// An item passes the states MUL, IDX, READ and UPDATE from accept to strobe, and
// the next one can be accepted in the strobe cycle: two multiply stages, then the
// count RAM read-modify-write on its single port.
// After reset the count RAM is swept to zero, with busy high.
// The response side cannot stall; each item gives exactly one strobe.
`default_nettype none

module light_grid_cell_append_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire lgca_pkg::req_type             req_item,
   output logic                               rsp_strobe,
   output lgca_pkg::rsp_type                  rsp_item,
   input  wire logic                          csr_we,
   input  wire logic [lgca_pkg::CSR_AW-1:0]   csr_index,
   input  wire logic [lgca_pkg::SIZE_W-1:0]   csr_wdata
);

   lgca_pkg::grid_cfg_type  grid_cfg_ff;
   lgca_pkg::dp_cmd_type    dp_cmd;
   lgca_pkg::dp_status_type dp_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            lgca_pkg::CSR_GRID_X: grid_cfg_ff.size_x <= csr_wdata;
            lgca_pkg::CSR_GRID_Y: grid_cfg_ff.size_y <= csr_wdata;
            lgca_pkg::CSR_GRID_Z: grid_cfg_ff.size_z <= csr_wdata;
            default: ;
         endcase
      end
   end

   lgca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   lgca_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .grid_cfg   (grid_cfg_ff),
      .req_item   (req_item),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

[bench/light_grid_cell_append_unit_tb.sv]
// Self-checking testbench for light_grid_cell_append_unit: directed and random
// cell appends over several grid sizes. Depends on lgca_pkg and the unit's RTL.
`timescale 1ns / 1ps

module light_grid_cell_append_unit_tb;

   // no register behind it
   localparam logic [lgca_pkg::CSR_AW-1:0] CSR_SPARE = 2'd3;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   lgca_pkg::req_type             req_item = '0;
   logic                          rsp_strobe;
   lgca_pkg::rsp_type             rsp_item;
   logic                          csr_we = 1'b0;
   logic [lgca_pkg::CSR_AW-1:0]   csr_index = '0;
   logic [lgca_pkg::SIZE_W-1:0]   csr_wdata = '0;

   light_grid_cell_append_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow of the grid registers and per-cell light counts
   int                           grid_x = 0;
   int                           grid_y = 0;
   int                           grid_z = 0;
   logic [lgca_pkg::COUNT_W-1:0] cell_fill [lgca_pkg::MAX_CELLS] = '{default: '0};

   lgca_pkg::req_type pending_appends_q[$];
   lgca_pkg::rsp_type predicted_q[$];
   lgca_pkg::rsp_type want;
   bit      steady_feed = 1'b0;
   int      gap_left = 0;
   int      next_gap;
   int      errors = 0;
   int      n_appended = 0;
   int      n_outside = 0;
   int      n_full = 0;
   int      n_settings = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic lgca_pkg::rsp_type append_to_cell(lgca_pkg::req_type item);
      lgca_pkg::rsp_type            r;
      int                           x, y, z;
      int unsigned                  lin;
      logic [lgca_pkg::COUNT_W-1:0] cnt;
      r = '0;
      r.status = lgca_pkg::STATUS_OUTSIDE;
      x = $signed(item.cell_x);
      y = $signed(item.cell_y);
      z = $signed(item.cell_z);
      if (x < 0 || y < 0 || z < 0 || x >= grid_x || y >= grid_y || z >= grid_z) begin
         n_outside++;
         return r;
      end
      lin = x + y * grid_x + z * grid_x * grid_y;
      if (lin >= lgca_pkg::MAX_CELLS) begin
         n_outside++;
         return r;
      end
      cnt = cell_fill[lin];
      r.cell_index = lin[lgca_pkg::CELL_AW-1:0];
      r.count_after = cnt;
      if (cnt >= lgca_pkg::SLOTS_PER_CELL) begin
         r.status = lgca_pkg::STATUS_FULL;
         n_full++;
         return r;
      end
      cell_fill[lin] = cnt + 1'b1;
      r.status = lgca_pkg::STATUS_APPENDED;
      r.slot = cnt[lgca_pkg::SLOT_AW-1:0];
      r.count_after = cnt + 1'b1;
      n_appended++;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_feed)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Driver: start stays high across back-to-back items
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         predicted_q.push_back(append_to_cell(req_item));
         next_gap = pick_gap();
         if (next_gap == 0 && pending_appends_q.size() != 0) begin
            req_item <= pending_appends_q.pop_front();
         end else begin
            start <= 1'b0;
            gap_left <= next_gap;
         end
      end else if (!start) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_appends_q.size() != 0) begin
            start <= 1'b1;
            req_item <= pending_appends_q.pop_front();
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (predicted_q.size() == 0) begin
            $error("response with nothing outstanding: status %0d cell %0d",
                   rsp_item.status, rsp_item.cell_index);
            errors++;
         end else begin
            want = predicted_q.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.cell_index !== want.cell_index) begin
               $error("cell_index: expected %0d, got %0d", want.cell_index,
                      rsp_item.cell_index);
               errors++;
            end
            if (rsp_item.slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_item.slot);
               errors++;
            end
            if (rsp_item.count_after !== want.count_after) begin
               $error("count_after: expected %0d, got %0d", want.count_after,
                      rsp_item.count_after);
               errors++;
            end
         end
      end
   end

   // Sampled at the falling edge, where nothing is in motion
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_appends_q.size() != 0 || start || predicted_q.size() != 0 || busy);
   endtask

   task automatic set_grid(input int sx, input int sy, input int sz);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= lgca_pkg::CSR_GRID_X;
      csr_wdata <= sx[lgca_pkg::SIZE_W-1:0];
      grid_x = sx;
      @(posedge clock);
      csr_index <= lgca_pkg::CSR_GRID_Y;
      csr_wdata <= sy[lgca_pkg::SIZE_W-1:0];
      grid_y = sy;
      @(posedge clock);
      csr_index <= lgca_pkg::CSR_GRID_Z;
      csr_wdata <= sz[lgca_pkg::SIZE_W-1:0];
      grid_z = sz;
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
      @(negedge clock);
   endtask

   task automatic queue_item(input int x, input int y, input int z, input int surf);
      lgca_pkg::req_type item;
      item.cell_x = x[lgca_pkg::COORD_W-1:0];
      item.cell_y = y[lgca_pkg::COORD_W-1:0];
      item.cell_z = z[lgca_pkg::COORD_W-1:0];
      item.light_id = surf[lgca_pkg::SURF_W-1:0];
      pending_appends_q.push_back(item);
   endtask

   // Mostly inside the grid; the rest is any byte
   function automatic int rand_coord(int size);
      if (size > 0 && $urandom_range(0, 99) < 85)
         return $urandom_range(0, size - 1);
      return $urandom_range(0, 255);
   endfunction

   task automatic run_phase(input int sx, input int sy, input int sz, input int n,
                            input bit steady);
      set_grid(sx, sy, sz);
      steady_feed = steady;
      repeat (n)
         queue_item(rand_coord(sx), rand_coord(sy), rand_coord(sz), $urandom_range(0, 255));
   endtask

   initial begin
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_idle();  // count RAM sweep

      // Grid of size zero: everything is outside
      queue_item(0, 0, 0, 0);
      queue_item(127, 127, 127, 255);
      queue_item(-128, -1, -128, 'hAA);

      // Write to the spare index must not change the grid
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= '1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      queue_item(0, 0, 0, 1);

      set_grid(32, 32, 32);
      queue_item(0, 0, 0, 0);
      queue_item(0, 0, 0, 255);
      queue_item(31, 31, 31, 'h55);
      queue_item(32, 0, 0, 1);
      queue_item(0, 32, 0, 2);
      queue_item(0, 0, 32, 3);
      queue_item(-1, 0, 0, 4);
      queue_item(0, -128, 0, 5);
      queue_item(0, 0, -1, 6);
      queue_item(1, 2, 3, 'h80);

      // Oversized registers: linear index can pass the cell store
      set_grid(63, 63, 63);
      queue_item(62, 62, 62, 7);
      queue_item(0, 0, 8, 8);
      queue_item(62, 62, 7, 9);
      queue_item(0, 0, 9, 10);
      queue_item(63, 0, 0, 11);

      // Random part; small grids fill cells up to the full case
      run_phase(1, 1, 1, 120, 1'b0);
      run_phase(2, 3, 2, 300, 1'b1);
      run_phase(3, 2, 1, 200, 1'b0);
      run_phase(32, 32, 32, 400, 1'b0);
      run_phase(63, 63, 63, 300, 1'b1);
      run_phase(0, 7, 5, 60, 1'b0);
      run_phase(5, 1, 6, 200, 1'b0);
      for (i = 0; i < 3; i++)
         run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 63), 150,
                   i == 1);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Covered %0d grid settings: %0d appends, %0d outside grid, %0d full list.",
               n_settings, n_appended, n_outside, n_full);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
